/* rtl/tmst_pkg.sv */
package tmst_pkg;

    // Default table depth and stored width of one value part.
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int FIELD_BITS = 32;
    localparam int TOL_BITS   = 31;
    localparam int ENTRY_BITS = 6;
    localparam int APB_BITS   = 32;
    localparam int ADDR_BITS  = 3;

    // Register index of the match tolerance (paddr[2]).
    localparam logic REG_MATCH_TOLERANCE = 1'b0;

    // Reset value of the match tolerance, about 0.1 in Q16.16.
    localparam logic [TOL_BITS-1:0] TOL_RESET = 31'd6554;

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Control flags of the search token that travels down the chain.
    typedef struct packed {
        logic valid;
        logic found;
    } tmst_flags_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } tmst_state_t;

endpackage

/* rtl/tmst_if.sv */
// Request channel: one lookup or insert item.
interface tmst_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] real_part;
    logic signed [31:0] imag_part;

    modport source (output valid, output op, output real_part, output imag_part,
                    input ready);
    modport sink   (input valid, input op, input real_part, input imag_part,
                    output ready);
endinterface

// Response channel: one result item per request.
interface tmst_rsp_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [5:0] entry_index;
    logic       inserted;
    logic       table_full;

    modport source (output valid, output hit, output entry_index, output inserted,
                    output table_full, input ready);
    modport sink   (input valid, input hit, input entry_index, input inserted,
                    input table_full, output ready);
endinterface

/* rtl/tmst_cell.sv */
module tmst_cell
    import tmst_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CELL_INDEX = 0,
    parameter int IDX_BITS   = 6,
    parameter int CNT_BITS   = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CNT_BITS-1:0]          count,
    input  logic [TOL_BITS-1:0]          tol,
    input  logic                         wr_en,
    input  logic signed [VALUE_BITS-1:0] wr_re,
    input  logic signed [VALUE_BITS-1:0] wr_im,
    input  tmst_flags_t                  flags_in,
    input  logic [IDX_BITS-1:0]          where_in,
    input  logic signed [VALUE_BITS-1:0] re_in,
    input  logic signed [VALUE_BITS-1:0] im_in,
    output tmst_flags_t                  flags_out,
    output logic [IDX_BITS-1:0]          where_out,
    output logic signed [VALUE_BITS-1:0] re_out,
    output logic signed [VALUE_BITS-1:0] im_out
);

    // Wide enough for an exact difference and for the tolerance.
    localparam int DW = (VALUE_BITS + 1 > TOL_BITS + 1) ? VALUE_BITS + 1 : TOL_BITS + 1;

    logic signed [VALUE_BITS-1:0] stored_re_reg;
    logic signed [VALUE_BITS-1:0] stored_im_reg;
    tmst_flags_t                  flags_reg;
    tmst_flags_t                  flags_next;
    logic [IDX_BITS-1:0]          where_reg;
    logic [IDX_BITS-1:0]          where_next;
    logic signed [VALUE_BITS-1:0] re_reg;
    logic signed [VALUE_BITS-1:0] im_reg;

    logic signed [DW-1:0] diff_re;
    logic signed [DW-1:0] diff_im;
    logic [DW-1:0]        abs_re;
    logic [DW-1:0]        abs_im;
    logic                 active;
    logic                 match;

    // Entry store of this cell, written when an insert lands here.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stored_re_reg <= wr_re;
            stored_im_reg <= wr_im;
        end
    end

    // Exact per-axis distance and strict compare against the tolerance.
    always_comb
    begin
        diff_re = DW'(stored_re_reg) - DW'(re_in);
        diff_im = DW'(stored_im_reg) - DW'(im_in);
        abs_re  = diff_re[DW-1] ? DW'(-diff_re) : DW'(diff_re);
        abs_im  = diff_im[DW-1] ? DW'(-diff_im) : DW'(diff_im);
        active  = count > CNT_BITS'(CELL_INDEX);
        match   = active && (abs_re < DW'(tol)) && (abs_im < DW'(tol));
    end

    // The first matching cell claims the token.
    always_comb
    begin
        flags_next = flags_in;
        where_next = where_in;
        if (flags_in.valid && !flags_in.found && match)
        begin
            flags_next.found = 1'b1;
            where_next       = IDX_BITS'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // Token payload handed to the next cell.
    always_ff @(posedge clk)
    begin
        where_reg <= where_next;
        re_reg    <= re_in;
        im_reg    <= im_in;
    end

    assign flags_out = flags_reg;
    assign where_out = where_reg;
    assign re_out    = re_reg;
    assign im_out    = im_reg;

endmodule

/* rtl/tmst_chain.sv */
module tmst_chain
    import tmst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IDX_BITS   = 6,
    parameter int CNT_BITS   = 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [CNT_BITS-1:0]          count,
    input  logic [TOL_BITS-1:0]          tol,
    input  logic                         commit,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] start_re,
    input  logic signed [VALUE_BITS-1:0] start_im,
    output tmst_flags_t                  end_flags,
    output logic [IDX_BITS-1:0]          end_where
);

    tmst_flags_t                  flags [CAPACITY+1];
    logic [IDX_BITS-1:0]          where [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] re    [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] im    [CAPACITY+1];

    // A new token enters the first cell with nothing found yet.
    assign flags[0].valid = start;
    assign flags[0].found = 1'b0;
    assign where[0]       = '0;
    assign re[0]          = start_re;
    assign im[0]          = start_im;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic wr_en;

        // An insert writes the value that left the chain into the next free cell.
        assign wr_en = commit && (count == CNT_BITS'(k));

        tmst_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CELL_INDEX (k),
            .IDX_BITS   (IDX_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .count     (count),
            .tol       (tol),
            .wr_en     (wr_en),
            .wr_re     (re[CAPACITY]),
            .wr_im     (im[CAPACITY]),
            .flags_in  (flags[k]),
            .where_in  (where[k]),
            .re_in     (re[k]),
            .im_in     (im[k]),
            .flags_out (flags[k+1]),
            .where_out (where[k+1]),
            .re_out    (re[k+1]),
            .im_out    (im[k+1])
        );
    end

    assign end_flags = flags[CAPACITY];
    assign end_where = where[CAPACITY];

endmodule

/* rtl/tolerance_match_set_table_core.sv */
// Channel   Dir  Payload                                       Handshake
// req       in   op, real_part, imag_part                      valid/ready
// rsp       out  hit, entry_index, inserted, table_full        valid/ready
// apb       in   psel, penable, pwrite, paddr, pwdata, prdata  pready tied high
//
// One item at a time: the search token walks the row of CAPACITY cells, one
// cell per cycle, and its result is then registered in the output register;
// no new item is taken while one is in the chain. A stalled result waits in
// the output register and a held copy; the next item is taken only once the
// finished one has been parked. Reset is asynchronous, active low, and
// empties the table with no sweep.
module tolerance_match_set_table_core
    import tmst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    tmst_req_if.sink             req,
    tmst_rsp_if.source           rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [APB_BITS-1:0]  pwdata,
    output logic [APB_BITS-1:0]  prdata,
    output logic                 pready
);

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int NB       = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    tmst_state_t state_reg;
    tmst_state_t state_next;

    logic [TOL_BITS-1:0] tol_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                op_reg;

    logic                out_valid_reg;
    logic                hit_reg;
    logic [ENTRY_BITS-1:0] index_reg;
    logic                inserted_reg;
    logic                full_reg;

    logic                pend_hit_reg;
    logic [ENTRY_BITS-1:0] pend_index_reg;
    logic                pend_inserted_reg;
    logic                pend_full_reg;

    logic                accept;
    logic                finish;
    logic                out_free;
    logic                load_out;
    logic                commit;
    logic                is_full;

    logic                res_hit;
    logic [ENTRY_BITS-1:0] res_index;
    logic                res_inserted;
    logic                res_full;

    logic signed [VALUE_BITS-1:0] q_re;
    logic signed [VALUE_BITS-1:0] q_im;

    tmst_flags_t                  end_flags;
    logic [IDX_BITS-1:0]          end_where;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATCH_TOLERANCE) ? APB_BITS'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MATCH_TOLERANCE)
        begin
            tol_reg <= pwdata[TOL_BITS-1:0];
        end
    end

    // Query parts cut to the stored precision and sign-extended.
    assign q_re = VALUE_BITS'(signed'(req.real_part[NB-1:0]));
    assign q_im = VALUE_BITS'(signed'(req.imag_part[NB-1:0]));

    tmst_chain #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IDX_BITS   (IDX_BITS),
        .CNT_BITS   (CNT_BITS)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count_reg),
        .tol       (tol_reg),
        .commit    (commit),
        .start     (accept),
        .start_re  (q_re),
        .start_im  (q_im),
        .end_flags (end_flags),
        .end_where (end_where)
    );

    // Result of the token that leaves the chain.
    always_comb
    begin
        is_full      = count_reg == CNT_BITS'(CAPACITY);
        res_hit      = end_flags.found;
        res_inserted = (op_reg == OP_INSERT) && !end_flags.found && !is_full;
        res_full     = (op_reg == OP_INSERT) && !end_flags.found && is_full;
        if (end_flags.found)
        begin
            res_index = ENTRY_BITS'(end_where);
        end
        else if (res_inserted)
        begin
            res_index = ENTRY_BITS'(count_reg);
        end
        else
        begin
            res_index = '0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (end_flags.valid)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req.ready = 1'b0;
        finish    = 1'b0;
        load_out  = 1'b0;
        out_free  = !out_valid_reg || rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                finish   = end_flags.valid;
                load_out = end_flags.valid && out_free;
            end
            ST_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept     = req.valid && req.ready;
    assign commit     = finish && res_inserted;
    assign count_next = commit ? count_reg + CNT_BITS'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Operation of the item in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.op;
        end
    end

    // Held copy of a finished result while the output is stalled.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            pend_hit_reg      <= res_hit;
            pend_index_reg    <= res_index;
            pend_inserted_reg <= res_inserted;
            pend_full_reg     <= res_full;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (state_reg == ST_SCAN)
            begin
                hit_reg      <= res_hit;
                index_reg    <= res_index;
                inserted_reg <= res_inserted;
                full_reg     <= res_full;
            end
            else
            begin
                hit_reg      <= pend_hit_reg;
                index_reg    <= pend_index_reg;
                inserted_reg <= pend_inserted_reg;
                full_reg     <= pend_full_reg;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.entry_index = index_reg;
    assign rsp.inserted    = inserted_reg;
    assign rsp.table_full  = full_reg;

endmodule
